/* rtl/core/rsi_pkg.sv */
// ---------------------------------------------------------------------------
// rsi_pkg
// shared widths, constants, types and helper functions of the rsi unit
// ---------------------------------------------------------------------------
package rsi_pkg;

    localparam int PRICE_W      = 32;
    localparam int AVG_FRAC_W   = 16;
    localparam int MOVE_W       = PRICE_W + AVG_FRAC_W;
    localparam int AVG_W        = MOVE_W + 6;
    localparam int SUM_W        = MOVE_W + 1;
    localparam int NUM_W        = 64;
    localparam int PERIOD_W     = 7;
    localparam int REM_W        = 6;
    localparam int RSI_W        = 15;
    localparam int OUT_DATA_W   = 16;
    localparam int RATIO_STEPS  = RSI_W;
    localparam int DIVN_STEPS   = AVG_W / 2;
    localparam int ITER_W       = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 7'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 7'd64;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;
    localparam logic [RSI_W-1:0]    RSI_HALF     = 15'd12800;

    typedef struct packed {
        logic load;
        logic move;
        logic acc;
        logic divn;
        logic prep1;
        logic prep2;
        logic divr;
        logic emit;
    } t_rsi_cmd;

    typedef struct packed {
        logic start_series;
        logic warming;
        logic warm_last;
        logic iter_done;
        logic out_free;
    } t_rsi_stat;

    function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] r;
        r = p;
        if (p < PERIOD_MIN) begin
            r = PERIOD_MIN;
        end else if (p > PERIOD_MAX) begin
            r = PERIOD_MAX;
        end
        return r;
    endfunction

    // one restoring step of a division by the period, returns {remainder, quotient bit}
    function automatic logic [REM_W:0] divn_step(input logic [REM_W-1:0] rem,
                                                  input logic din,
                                                  input logic [PERIOD_W-1:0] n);
        logic [PERIOD_W-1:0] t;
        logic [PERIOD_W-1:0] d;
        t = {rem, din};
        d = t - n;
        if (t >= n) begin
            return {d[REM_W-1:0], 1'b1};
        end
        return {t[REM_W-1:0], 1'b0};
    endfunction

endpackage

/* rtl/core/rsi_ctrl.sv */
// ---------------------------------------------------------------------------
// rsi_ctrl
// sequencer of the rsi unit: steps one request through update and, when a result is due, divide and ratio
// ---------------------------------------------------------------------------
module rsi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  rsi_pkg::t_rsi_stat i_stat,
    output rsi_pkg::t_rsi_cmd  o_cmd
);
    import rsi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOVE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DIVN  = 3'd3;
    localparam logic [2:0] S_PREP1 = 3'd4;
    localparam logic [2:0] S_PREP2 = 3'd5;
    localparam logic [2:0] S_DIVR  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = i_stat.start_series ? S_IDLE : S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = (i_stat.warming && !i_stat.warm_last) ? S_IDLE : S_DIVN;
            end
            S_DIVN: begin
                o_cmd.divn = 1'b1;
                if (i_stat.iter_done) begin
                    n_state = S_PREP1;
                end
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.divr = 1'b1;
                if (i_stat.iter_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/rsi_datapath.sv */
// ---------------------------------------------------------------------------
// rsi_datapath
// price history, wilder averages, serial dividers and output register
// ---------------------------------------------------------------------------
module rsi_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0] i_cfg_wr_data,
    input  logic [rsi_pkg::PRICE_W-1:0]  i_price,
    input  logic                         i_restart,
    input  rsi_pkg::t_rsi_cmd            i_cmd,
    output rsi_pkg::t_rsi_stat           o_stat,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [rsi_pkg::RSI_W-1:0]    o_rsi,
    output logic                         o_flat
);
    import rsi_pkg::*;

    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PRICE_W-1:0]  r_price, n_price;
    logic                r_restart, n_restart;
    logic [PRICE_W-1:0]  r_prev, n_prev;
    logic                r_have_prev, n_have_prev;
    logic [PERIOD_W-1:0] r_cnt, n_cnt;
    logic [AVG_W-1:0]    r_gain, n_gain;
    logic [AVG_W-1:0]    r_loss, n_loss;
    logic [REM_W-1:0]    r_rem_g, n_rem_g;
    logic [REM_W-1:0]    r_rem_l, n_rem_l;
    logic [MOVE_W-1:0]   r_up, n_up;
    logic [MOVE_W-1:0]   r_down, n_down;
    logic [AVG_W-1:0]    r_mg, n_mg;
    logic [AVG_W-1:0]    r_ml, n_ml;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [NUM_W-1:0]    r_rq, n_rq;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_out_valid, n_out_valid;
    logic [RSI_W-1:0]    r_out_rsi, n_out_rsi;
    logic                r_out_flat, n_out_flat;

    logic [PERIOD_W-1:0] per_n;
    logic [PERIOD_W-1:0] per_nm1;
    logic [PRICE_W-1:0]  diff_up;
    logic [PRICE_W-1:0]  diff_down;
    logic                rising;
    logic [REM_W:0]      g_s1, g_s0, l_s1, l_s0;
    logic [NUM_W-1:0]    gain_ext;
    logic [SUM_W:0]      rt;
    logic [SUM_W:0]      rd;

    assign per_n     = clamp_period(r_period);
    assign per_nm1   = per_n - 7'd1;
    assign rising    = (r_price >= r_prev);
    assign diff_up   = r_price - r_prev;
    assign diff_down = r_prev - r_price;
    assign gain_ext  = NUM_W'(r_gain);

    assign g_s1 = divn_step(r_rem_g, r_gain[AVG_W-1], per_n);
    assign g_s0 = divn_step(g_s1[REM_W:1], r_gain[AVG_W-2], per_n);
    assign l_s1 = divn_step(r_rem_l, r_loss[AVG_W-1], per_n);
    assign l_s0 = divn_step(l_s1[REM_W:1], r_loss[AVG_W-2], per_n);

    assign rt = {r_rq[NUM_W-1:RATIO_STEPS], r_rq[RATIO_STEPS-1]};
    assign rd = rt - {1'b0, r_sum};

    assign o_stat.start_series = r_restart || !r_have_prev;
    assign o_stat.warming      = (r_cnt < per_n);
    assign o_stat.warm_last    = (r_cnt == per_nm1);
    assign o_stat.iter_done    = (r_iter == '0);
    assign o_stat.out_free     = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_rsi      = r_out_rsi;
    assign o_flat     = r_out_flat;

    always_comb begin
        n_period    = r_period;
        n_price     = r_price;
        n_restart   = r_restart;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        n_gain      = r_gain;
        n_loss      = r_loss;
        n_rem_g     = r_rem_g;
        n_rem_l     = r_rem_l;
        n_up        = r_up;
        n_down      = r_down;
        n_mg        = r_mg;
        n_ml        = r_ml;
        n_sum       = r_sum;
        n_rq        = r_rq;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        n_out_rsi   = r_out_rsi;
        n_out_flat  = r_out_flat;

        if (i_cmd.load) begin
            n_price   = i_price;
            n_restart = i_restart;
        end

        if (i_cmd.move) begin
            n_prev = r_price;
            if (r_restart || !r_have_prev) begin
                n_have_prev = 1'b1;
                n_cnt       = '0;
                n_gain      = '0;
                n_loss      = '0;
            end else begin
                n_up   = rising ? {diff_up, AVG_FRAC_W'(0)} : '0;
                n_down = rising ? '0 : {diff_down, AVG_FRAC_W'(0)};
                n_mg   = AVG_W'(r_gain[MOVE_W-1:0]) * AVG_W'(per_nm1[REM_W-1:0]);
                n_ml   = AVG_W'(r_loss[MOVE_W-1:0]) * AVG_W'(per_nm1[REM_W-1:0]);
            end
        end

        if (i_cmd.acc) begin
            if (r_cnt < per_n) begin
                n_gain = r_gain + AVG_W'(r_up);
                n_loss = r_loss + AVG_W'(r_down);
                n_cnt  = r_cnt + 7'd1;
            end else begin
                n_gain = r_mg + AVG_W'(r_up);
                n_loss = r_ml + AVG_W'(r_down);
            end
            n_rem_g = '0;
            n_rem_l = '0;
            n_iter  = ITER_W'(DIVN_STEPS - 1);
        end

        // two quotient bits per cycle for each average
        if (i_cmd.divn) begin
            n_gain  = {r_gain[AVG_W-3:0], g_s1[0], g_s0[0]};
            n_loss  = {r_loss[AVG_W-3:0], l_s1[0], l_s0[0]};
            n_rem_g = g_s0[REM_W:1];
            n_rem_l = l_s0[REM_W:1];
            n_iter  = r_iter - ITER_W'(1);
        end

        // numerator gain * 25600 + sum / 2, built from shifted terms
        if (i_cmd.prep1) begin
            n_sum = r_gain[SUM_W-1:0] + r_loss[SUM_W-1:0];
            n_rq  = (gain_ext << 14) + (gain_ext << 13);
        end

        if (i_cmd.prep2) begin
            n_rq   = r_rq + (gain_ext << 10) + NUM_W'(r_sum[SUM_W-1:1]);
            n_iter = ITER_W'(RATIO_STEPS - 1);
        end

        if (i_cmd.divr) begin
            if (rt >= {1'b0, r_sum}) begin
                n_rq = {rd[SUM_W-1:0], r_rq[RATIO_STEPS-2:0], 1'b1};
            end else begin
                n_rq = {rt[SUM_W-1:0], r_rq[RATIO_STEPS-2:0], 1'b0};
            end
            n_iter = r_iter - ITER_W'(1);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_flat  = (r_sum == '0);
            n_out_rsi   = (r_sum == '0) ? RSI_HALF : r_rq[RSI_W-1:0];
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            n_period    = i_cfg_wr_data;
            n_have_prev = 1'b0;
            n_cnt       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_period    <= n_period;
            r_have_prev <= n_have_prev;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_iter      <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price    <= n_price;
        r_restart  <= n_restart;
        r_prev     <= n_prev;
        r_gain     <= n_gain;
        r_loss     <= n_loss;
        r_rem_g    <= n_rem_g;
        r_rem_l    <= n_rem_l;
        r_up       <= n_up;
        r_down     <= n_down;
        r_mg       <= n_mg;
        r_ml       <= n_ml;
        r_sum      <= n_sum;
        r_rq       <= n_rq;
        r_out_rsi  <= n_out_rsi;
        r_out_flat <= n_out_flat;
    end

endmodule

/* rtl/core/relative_strength_index_unit.sv */
// ---------------------------------------------------------------------------
// relative_strength_index_unit
// wilder relative strength index over a stream of q24.8 closing prices
// ---------------------------------------------------------------------------
// One closing price per request. A price that starts a series passes through
// the load and move states before the next request can be taken, and a change
// inside the warm-up window also through the accumulate state. A price that
// produces a result waits for the output register to be free: the two averages
// are divided by the period in two radix-4 serial dividers running side by side,
// then the ratio 100 * gain / (gain + loss) goes through a restoring divider. The
// result waits in an output register, so the next price is taken while it is
// still pending. Writing the period clears the series history.
module relative_strength_index_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]   i_cfg_wr_data,   // period_length
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rsi_pkg::PRICE_W-1:0]    i_s_tdata,       // close_price
    input  logic                           i_s_tuser,       // restart_series
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rsi_pkg::OUT_DATA_W-1:0] o_m_tdata,       // rsi_value, zero pad
    output logic                           o_m_tuser        // flat_market
);
    import rsi_pkg::*;

    t_rsi_cmd         cmd;
    t_rsi_stat        stat;
    logic [RSI_W-1:0] rsi;

    rsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rsi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_price       (i_s_tdata),
        .i_restart     (i_s_tuser),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_rsi         (rsi),
        .o_flat        (o_m_tuser)
    );

    assign o_m_tdata = OUT_DATA_W'(rsi);

endmodule

/* sim/relative_strength_index_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// relative_strength_index_unit_tb
// self-checking bench for the wilder rsi unit
// ---------------------------------------------------------------------------
// Drives q24.8 closing prices on the input stream and checks each rsi result
// against a cycle-free model of the unit kept in the bench or, for marked rows,
// the table value. A short table of hand-picked requests comes first (flat market, full
// gain, full loss, restart), then random price walks under a series of period settings,
// the clamped extremes included. Both stream sides stall at random in bursts.
// ---------------------------------------------------------------------------
module relative_strength_index_unit_tb;

    import rsi_pkg::*;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          RANDOM_ITEMS = 1050;
    localparam logic [63:0] AVG_CAP      = (64'd1 << 57) - 64'd1;
    localparam logic [63:0] RATIO_LIMIT  = 64'd1 << 49;
    localparam logic [63:0] RSI_FULL     = 64'd25600;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             flat;
    } t_rsi_result;

    typedef struct {
        bit                  wr_period;
        logic [PERIOD_W-1:0] period;
        logic [PRICE_W-1:0]  close;
        bit                  restart;
        bit                  fixed;
        logic [RSI_W-1:0]    rsi;
        bit                  flat;
    } t_stim_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0]   i_cfg_wr_data = '0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [PRICE_W-1:0]    i_s_tdata     = '0;   // close_price
    logic                  i_s_tuser     = 1'b0; // restart_series
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;            // rsi_value, zero pad
    logic                  o_m_tuser;            // flat_market

    // model state
    logic [PERIOD_W-1:0] period_reg;
    logic [PRICE_W-1:0]  last_close;
    logic [63:0]         gain_avg;
    logic [63:0]         loss_avg;
    logic [PERIOD_W-1:0] warm_cnt;
    bit                  have_close;

    t_rsi_result pending_rsi_q[$];
    t_rsi_result rsi_head;

    int  fail_count    = 0;
    int  results_seen  = 0;
    int  flat_seen     = 0;
    int  prices_sent   = 0;
    int  period_writes = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  src_idle_en   = 1'b0;
    bit  sink_idle_en  = 1'b0;

    relative_strength_index_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_m_tready <= 1'b1;
        end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_rsi_q.size() == 0) begin
                $error("unexpected result: rsi_value %0d flat_market %0d",
                       o_m_tdata[RSI_W-1:0], o_m_tuser);
                fail_count++;
            end else begin
                rsi_head = pending_rsi_q.pop_front();
                if (rsi_head.flat) flat_seen++;
                if (o_m_tdata[RSI_W-1:0] !== rsi_head.rsi) begin
                    $error("rsi_value: expected %0d, actual %0d",
                           rsi_head.rsi, o_m_tdata[RSI_W-1:0]);
                    fail_count++;
                end
                if (o_m_tuser !== rsi_head.flat) begin
                    $error("flat_market: expected %0d, actual %0d",
                           rsi_head.flat, o_m_tuser);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [63:0] cap_avg(input logic [63:0] v);
        return (v > AVG_CAP) ? AVG_CAP : v;
    endfunction

    function automatic void clear_series();
        last_close = '0;
        gain_avg   = '0;
        loss_avg   = '0;
        warm_cnt   = '0;
        have_close = 1'b0;
    endfunction

    function automatic void step_rsi(input logic [PRICE_W-1:0] price, input bit restart,
                                     output bit has_res, output t_rsi_result res);
        logic [63:0] n;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] g;
        logic [63:0] l;
        logic [63:0] total;
        has_res = 1'b0;
        res     = '0;
        up      = '0;
        down    = '0;
        n       = 64'(period_reg);
        if (period_reg < PERIOD_MIN) n = 64'(PERIOD_MIN);
        if (period_reg > PERIOD_MAX) n = 64'(PERIOD_MAX);
        if (restart) clear_series();
        if (!have_close) begin
            last_close = price;
            have_close = 1'b1;
            return;
        end
        if (price >= last_close) begin
            up = cap_avg(64'(price - last_close) << AVG_FRAC_W);
        end else begin
            down = cap_avg(64'(last_close - price) << AVG_FRAC_W);
        end
        last_close = price;
        if (64'(warm_cnt) < n) begin
            gain_avg = cap_avg(gain_avg + up);
            loss_avg = cap_avg(loss_avg + down);
            warm_cnt = warm_cnt + 1'b1;
            if (64'(warm_cnt) < n) return;
            gain_avg = gain_avg / n;
            loss_avg = loss_avg / n;
        end else begin
            gain_avg = cap_avg((gain_avg * (n - 1) + up) / n);
            loss_avg = cap_avg((loss_avg * (n - 1) + down) / n);
        end
        has_res = 1'b1;
        g = gain_avg;
        l = loss_avg;
        while (g + l >= RATIO_LIMIT) begin
            g = g >> 1;
            l = l >> 1;
        end
        total = g + l;
        if (total == 0) begin
            res.rsi  = RSI_HALF;
            res.flat = 1'b1;
        end else begin
            res.rsi  = RSI_W'((g * RSI_FULL + (total >> 1)) / total);
            res.flat = 1'b0;
        end
    endfunction

    task automatic send_close(input logic [PRICE_W-1:0] price, input bit restart,
                              input bit fixed, input logic [RSI_W-1:0] exp_rsi,
                              input bit exp_flat);
        bit          has_res;
        t_rsi_result res;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= price;
        i_s_tuser  <= restart;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        prices_sent++;
        step_rsi(price, restart, has_res, res);
        if (fixed) begin
            if (!has_res) begin
                $error("request %0d: model gives no result where one is due", prices_sent);
                fail_count++;
            end
            has_res  = 1'b1;
            res.rsi  = exp_rsi;
            res.flat = exp_flat;
        end
        if (has_res) pending_rsi_q = {pending_rsi_q, res};
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] p);
        i_s_tvalid <= 1'b0;
        while (pending_rsi_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= p;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        period_reg = p;
        clear_series();
        period_writes++;
    endtask

    function automatic t_stim_row price_row(input logic [PRICE_W-1:0] close,
                                            input bit restart, input bit fixed,
                                            input logic [RSI_W-1:0] rsi, input bit flat);
        t_stim_row r;
        r.wr_period = 1'b0;
        r.period    = '0;
        r.close     = close;
        r.restart   = restart;
        r.fixed     = fixed;
        r.rsi       = rsi;
        r.flat      = flat;
        return r;
    endfunction

    initial begin
        t_stim_row          rows[$];
        t_stim_row          wr;
        logic [PERIOD_W-1:0] phase_periods[$];
        logic [PERIOD_W-1:0] p;
        logic [PRICE_W-1:0]  price;
        logic [PRICE_W-1:0]  delta;
        int                 random_sent;
        int                 phase;
        int                 phase_items;
        int                 up_bias;
        int                 pick;
        int                 n_eff;

        period_reg = PERIOD_RESET;
        clear_series();

        // reset period, fifteen equal closes: no gain and no loss
        rows = {rows, price_row(32'h0000_6400, 1'b1, 1'b0, '0, 1'b0)};
        for (int k = 1; k < 14; k++) begin
            rows = {rows, price_row(32'h0000_6400, 1'b0, 1'b0, '0, 1'b0)};
        end
        rows = {rows, price_row(32'h0000_6400, 1'b0, 1'b1, RSI_HALF, 1'b1)};
        wr.wr_period = 1'b1;
        wr.period    = PERIOD_MIN;
        rows = {rows, wr};
        // full gain, then a full loss
        rows = {rows, price_row(32'h0000_0000, 1'b0, 1'b0, '0, 1'b0)};
        rows = {rows, price_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0)};
        rows = {rows, price_row(32'hFFFF_FFFF, 1'b0, 1'b1, RSI_W'(25600), 1'b0)};
        rows = {rows, price_row(32'h0000_0000, 1'b0, 1'b0, '0, 1'b0)};
        // restart, then losses only
        rows = {rows, price_row(32'h0000_0005, 1'b1, 1'b0, '0, 1'b0)};
        rows = {rows, price_row(32'h0000_0003, 1'b0, 1'b0, '0, 1'b0)};
        rows = {rows, price_row(32'h0000_0003, 1'b0, 1'b1, '0, 1'b0)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].wr_period) begin
                set_period(rows[k].period);
            end else begin
                send_close(rows[k].close, rows[k].restart, rows[k].fixed,
                           rows[k].rsi, rows[k].flat);
            end
        end

        phase_periods = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd3, 7'd2, PERIOD_RESET};
        random_sent = 0;
        phase = 0;
        price = $urandom();
        while (random_sent < RANDOM_ITEMS) begin
            if (phase < phase_periods.size()) begin
                p = phase_periods[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                p = $urandom_range(0, 127);
            end else begin
                p = $urandom_range(2, 16);
            end
            set_period(p);
            phase++;
            n_eff = (p < PERIOD_MIN) ? PERIOD_MIN : (p > PERIOD_MAX) ? PERIOD_MAX : p;
            phase_items = $urandom_range(n_eff + 5, n_eff + 80);
            up_bias = $urandom_range(15, 85);
            src_idle_en  = (random_sent < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (random_sent < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++) begin
                if (random_sent >= RANDOM_ITEMS - 150) begin
                    src_idle_en  = 1'b0;
                    sink_idle_en = 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    delta = (pick < 60) ? $urandom_range(0, 'h3FF) : $urandom_range(0, 'hFFFFF);
                    if ($urandom_range(0, 99) < up_bias) price = price + delta;
                    else price = price - delta;
                end else if (pick < 85) begin
                    price = price;
                end else if (pick < 95) begin
                    price = $urandom();
                end else begin
                    price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end
                send_close(price, $urandom_range(0, 29) == 0, 1'b0, '0, 1'b0);
                random_sent++;
            end
        end
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        i_s_tvalid <= 1'b0;

        while (pending_rsi_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d close prices sent under %0d period settings", prices_sent,
                 period_writes + 1);
        $display("%0d rsi results checked, %0d of them flat market", results_seen, flat_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* relative_strength_index_unit.f */
rtl/core/rsi_pkg.sv
rtl/core/rsi_ctrl.sv
rtl/core/rsi_datapath.sv
rtl/core/relative_strength_index_unit.sv
sim/relative_strength_index_unit_tb.sv
